/* rtl/core/rpd_pkg.sv */
package rpd_pkg;

  localparam int TOKEN_MAX = 5;
  localparam int TLEN_W    = $clog2(TOKEN_MAX + 1);

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam int OUT_TDATA_W = 48;

  localparam logic [16:0] DIM_MAX     = 17'd99999;
  localparam logic [7:0]  RUN_BASE    = 8'h80;
  localparam logic [7:0]  TOKEN_SPACE = 8'h20;

  localparam logic [1:0] KIND_HEADER = 2'd0;
  localparam logic [1:0] KIND_PIXEL  = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [1:0] MODE_COUNTER = 2'd0;
  localparam logic [1:0] MODE_LITERAL = 2'd1;
  localparam logic [1:0] MODE_REPEAT  = 2'd2;
  localparam logic [1:0] MODE_FOREVER = 2'd3;

  localparam logic [2:0] PH_MAGIC  = 3'd0;
  localparam logic [2:0] PH_WIDTH  = 3'd1;
  localparam logic [2:0] PH_HEIGHT = 3'd2;
  localparam logic [2:0] PH_MAXCOL = 3'd3;
  localparam logic [2:0] PH_PIXELS = 3'd4;
  localparam logic [2:0] PH_ERROR  = 3'd5;

  typedef struct packed {
    logic [7:0] data;
    logic [6:0] count;
    logic       eos;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] width;
    logic [16:0] height;
    logic [7:0]  index;
  } result_t;

  function automatic logic [7:0] palette_index(input logic [7:0] r, input logic [7:0] g,
                                               input logic [7:0] b);
    logic [2:0] rq;
    logic [2:0] gq;
    logic [2:0] bq;
    rq = 3'(r >= 8'd51) + 3'(r >= 8'd102) + 3'(r >= 8'd153) + 3'(r >= 8'd204)
       + 3'(r == 8'd255);
    gq = 3'(g >= 8'd43) + 3'(g >= 8'd85) + 3'(g >= 8'd128) + 3'(g >= 8'd170)
       + 3'(g >= 8'd213) + 3'(g == 8'd255);
    bq = 3'(b >= 8'd51) + 3'(b >= 8'd102) + 3'(b >= 8'd153) + 3'(b >= 8'd204)
       + 3'(b == 8'd255);
    return {5'b0, rq} * 8'd42 + {5'b0, gq} * 8'd6 + {5'b0, bq};
  endfunction

endpackage

/* rtl/core/rpd_front.sv */
module rpd_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [7:0]    in_tdata,
  input  logic          in_tlast,
  output logic          push_valid,
  output rpd_pkg::cmd_t push_cmd,
  input  logic          q_full
);
  import rpd_pkg::*;

  logic [1:0] mode_r, mode_nxt;
  logic [7:0] run_r, run_nxt;
  logic [6:0] cnt;
  logic       acc;

  assign in_tready = !q_full;
  assign acc       = in_tvalid && in_tready;

  always_comb begin
    mode_nxt = mode_r;
    run_nxt  = run_r;
    cnt      = '0;
    case (mode_r)
      MODE_COUNTER: begin
        if (in_tdata == 8'd0) begin
          mode_nxt = MODE_FOREVER;
        end else if (in_tdata > RUN_BASE) begin
          mode_nxt = MODE_REPEAT;
          run_nxt  = in_tdata - RUN_BASE;
        end else begin
          mode_nxt = MODE_LITERAL;
          run_nxt  = in_tdata;
        end
      end
      MODE_LITERAL: begin
        cnt = 7'd1;
        if (run_r <= 8'd1) begin
          mode_nxt = MODE_COUNTER;
          run_nxt  = '0;
        end else begin
          run_nxt = run_r - 8'd1;
        end
      end
      MODE_REPEAT: begin
        cnt      = run_r[6:0];
        run_nxt  = '0;
        mode_nxt = MODE_COUNTER;
      end
      default: begin
        cnt = 7'd1;
      end
    endcase
    if (in_tlast) begin
      mode_nxt = MODE_COUNTER;
      run_nxt  = '0;
    end
  end

  assign push_valid     = acc && (cnt != 7'd0 || in_tlast);
  assign push_cmd.data  = in_tdata;
  assign push_cmd.count = cnt;
  assign push_cmd.eos   = in_tlast;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_COUNTER;
      run_r  <= '0;
    end else if (acc) begin
      mode_r <= mode_nxt;
      run_r  <= run_nxt;
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    acc && in_tlast |=> mode_r == MODE_COUNTER && run_r == 8'd0)
    else $error("run state not cleared after end of stream");
`endif

endmodule

/* rtl/core/rpd_queue.sv */
module rpd_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpd_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output rpd_pkg::cmd_t head_cmd
);
  import rpd_pkg::*;

  cmd_t              mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QPTR_W:0]   cnt_r;

  assign full       = cnt_r == (QPTR_W + 1)'(QDEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (QPTR_W + 1)'(1);
        2'b01:   cnt_r <= cnt_r - (QPTR_W + 1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    (push |-> !full) and (pop |-> head_valid))
    else $error("queue overflow or underflow");
`endif

endmodule

/* rtl/core/rpd_back.sv */
module rpd_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cmd_valid,
  input  rpd_pkg::cmd_t                    cmd,
  output logic                             cmd_pop,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rpd_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic [1:0]                       out_tuser,
  output logic                             out_tlast
);
  import rpd_pkg::*;

  logic              busy_r, busy_nxt;
  logic [7:0]        byte_r, byte_nxt;
  logic [6:0]        cnt_r, cnt_nxt;
  logic              eos_r, eos_nxt;
  logic [2:0]        phase_r, phase_nxt;
  logic [TLEN_W-1:0] tlen_r, tlen_nxt;
  logic              magic_r, magic_nxt;
  logic              dig_r, dig_nxt;
  logic              neg_r, neg_nxt;
  logic [16:0]       val_r, val_nxt;
  logic [16:0]       width_r, width_nxt;
  logic [16:0]       height_r, height_nxt;
  logic [7:0]        pend0_r, pend0_nxt;
  logic [7:0]        pend1_r, pend1_nxt;
  logic [1:0]        pcnt_r, pcnt_nxt;
  logic              hold_v_r, hold_v_nxt;
  result_t           hold_r, hold_nxt;
  logic              out_v_r, out_v_nxt;
  result_t           out_r, out_nxt;
  logic              out_last_r, out_last_nxt;

  logic              go;
  logic              finish;
  logic              do_feed;
  logic              do_tdone;
  logic              gen_v;
  result_t           gen;
  logic [16:0]       number;
  logic [19:0]       val_mul;
  logic [3:0]        digit;
  logic              is_digit;

  assign go       = !out_v_r || out_tready;
  assign cmd_pop  = !busy_r && cmd_valid;
  assign number   = neg_r ? 17'd0 : val_r;
  assign digit    = byte_r[3:0] - 4'd0;
  assign is_digit = byte_r >= "0" && byte_r <= "9";
  assign val_mul  = {val_r, 3'b0} + {2'b0, val_r, 1'b0} + {16'b0, digit};

  always_comb begin
    busy_nxt     = busy_r;
    byte_nxt     = byte_r;
    cnt_nxt      = cnt_r;
    eos_nxt      = eos_r;
    phase_nxt    = phase_r;
    tlen_nxt     = tlen_r;
    magic_nxt    = magic_r;
    dig_nxt      = dig_r;
    neg_nxt      = neg_r;
    val_nxt      = val_r;
    width_nxt    = width_r;
    height_nxt   = height_r;
    pend0_nxt    = pend0_r;
    pend1_nxt    = pend1_r;
    pcnt_nxt     = pcnt_r;
    hold_v_nxt   = hold_v_r;
    hold_nxt     = hold_r;
    out_v_nxt    = out_v_r && !out_tready;
    out_nxt      = out_r;
    out_last_nxt = out_last_r;
    finish       = 1'b0;
    do_feed      = 1'b0;
    do_tdone     = 1'b0;
    gen_v        = 1'b0;
    gen          = '0;

    if (cmd_pop) begin
      busy_nxt = 1'b1;
      byte_nxt = cmd.data;
      cnt_nxt  = cmd.count;
      eos_nxt  = cmd.eos;
    end else if (busy_r && go) begin
      if (cnt_r != 7'd0) begin
        do_feed = 1'b1;
        cnt_nxt = cnt_r - 7'd1;
      end else if (eos_r && phase_r <= PH_MAXCOL) begin
        do_tdone = 1'b1;
      end else begin
        finish   = 1'b1;
        busy_nxt = 1'b0;
      end
    end

    if (do_feed) begin
      if (phase_r == PH_PIXELS) begin
        if (pcnt_r == 2'd0) begin
          pend0_nxt = byte_r;
          pcnt_nxt  = 2'd1;
        end else if (pcnt_r == 2'd1) begin
          pend1_nxt = byte_r;
          pcnt_nxt  = 2'd2;
        end else begin
          gen_v     = 1'b1;
          gen.kind  = KIND_PIXEL;
          gen.index = palette_index(pend0_r, pend1_r, byte_r);
          pcnt_nxt  = 2'd0;
        end
      end else if (phase_r != PH_ERROR) begin
        if (byte_r <= TOKEN_SPACE || tlen_r >= TLEN_W'(TOKEN_MAX)) begin
          do_tdone = 1'b1;
        end else begin
          tlen_nxt = tlen_r + TLEN_W'(1);
          if (tlen_r == TLEN_W'(0)) begin
            magic_nxt = byte_r == "P";
          end else if (tlen_r == TLEN_W'(1)) begin
            magic_nxt = magic_r && byte_r == "6";
          end
          if (tlen_r == TLEN_W'(0) && (byte_r == "+" || byte_r == "-")) begin
            neg_nxt = byte_r == "-";
          end else if (dig_r && is_digit) begin
            val_nxt = (val_mul > {3'b0, DIM_MAX}) ? DIM_MAX : val_mul[16:0];
          end else begin
            dig_nxt = 1'b0;
          end
        end
      end
    end

    if (do_tdone) begin
      case (phase_r)
        PH_MAGIC: begin
          if (tlen_r == TLEN_W'(2) && magic_r) begin
            phase_nxt = PH_WIDTH;
          end else begin
            gen_v     = 1'b1;
            gen.kind  = KIND_ERROR;
            phase_nxt = PH_ERROR;
          end
        end
        PH_WIDTH: begin
          width_nxt = number;
          phase_nxt = PH_HEIGHT;
        end
        PH_HEIGHT: begin
          height_nxt = number;
          phase_nxt  = PH_MAXCOL;
        end
        default: begin
          gen_v      = 1'b1;
          gen.kind   = KIND_HEADER;
          gen.width  = width_r;
          gen.height = height_r;
          phase_nxt  = PH_PIXELS;
        end
      endcase
      tlen_nxt  = '0;
      magic_nxt = 1'b0;
      dig_nxt   = 1'b1;
      neg_nxt   = 1'b0;
      val_nxt   = '0;
    end

    if (gen_v) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = hold_r;
        out_last_nxt = 1'b0;
      end
      hold_v_nxt = 1'b1;
      hold_nxt   = gen;
    end

    if (finish) begin
      if (hold_v_r) begin
        out_v_nxt    = 1'b1;
        out_nxt      = hold_r;
        out_last_nxt = 1'b1;
        hold_v_nxt   = 1'b0;
      end
      if (eos_r) begin
        phase_nxt  = PH_MAGIC;
        tlen_nxt   = '0;
        magic_nxt  = 1'b0;
        dig_nxt    = 1'b1;
        neg_nxt    = 1'b0;
        val_nxt    = '0;
        width_nxt  = '0;
        height_nxt = '0;
        pcnt_nxt   = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      cnt_r    <= '0;
      eos_r    <= 1'b0;
      phase_r  <= PH_MAGIC;
      tlen_r   <= '0;
      magic_r  <= 1'b0;
      dig_r    <= 1'b1;
      neg_r    <= 1'b0;
      val_r    <= '0;
      width_r  <= '0;
      height_r <= '0;
      pcnt_r   <= '0;
      hold_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      busy_r   <= busy_nxt;
      cnt_r    <= cnt_nxt;
      eos_r    <= eos_nxt;
      phase_r  <= phase_nxt;
      tlen_r   <= tlen_nxt;
      magic_r  <= magic_nxt;
      dig_r    <= dig_nxt;
      neg_r    <= neg_nxt;
      val_r    <= val_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pcnt_r   <= pcnt_nxt;
      hold_v_r <= hold_v_nxt;
      out_v_r  <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r     <= byte_nxt;
    pend0_r    <= pend0_nxt;
    pend1_r    <= pend1_nxt;
    hold_r     <= hold_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_v_r;
  assign out_tuser  = out_r.kind;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {(OUT_TDATA_W - 42)'(0), out_r.index, out_r.height, out_r.width};

`ifndef SYNTHESIS
  assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !hold_v_r)
    else $error("held result left behind after item completed");
  assert property (@(posedge clk) disable iff (!rst_n)
    finish && eos_r |=> phase_r == PH_MAGIC && pcnt_r == 2'd0 && tlen_r == '0)
    else $error("parser not restarted after end of stream");
`endif

endmodule

/* rtl/core/rle_ppm_to_palette_decoder.sv */
// Channel  Direction  tdata (low bit up)                           tuser  tlast
// in_      slave      data_byte[7:0]                               -      end_of_stream
// out_     master     image_width[16:0] image_height[33:17]        kind   last
//                     color_index[41:34] zero[47:42]
//
// The back end loads each queued item, feeds its decoded bytes one by one (a repeat run of n
// feeds n) and completes it before it takes the next; a bare counter item never enters the queue.
// An end-of-stream item also closes each header token still open (up to four).
// rst_n is synchronous and active low; it clears the run state, parser and queue.
// in_tready drops only while the 4-entry queue is full; out_tready low stalls the back end.
module rle_ppm_to_palette_decoder (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [7:0]                       in_tdata,   // data_byte
  input  logic                             in_tlast,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [rpd_pkg::OUT_TDATA_W-1:0]  out_tdata,  // image_width, image_height, color_index
  output logic [1:0]                       out_tuser,  // kind
  output logic                             out_tlast
);
  import rpd_pkg::*;

  logic push_valid;
  cmd_t push_cmd;
  logic q_full;
  logic head_valid;
  cmd_t head_cmd;
  logic cmd_pop;

  rpd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .q_full     (q_full)
  );

  rpd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push_valid),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (cmd_pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  rpd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (head_valid),
    .cmd        (head_cmd),
    .cmd_pop    (cmd_pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

/* dv/rle_ppm_to_palette_decoder_tb.sv */
`default_nettype none

module rle_ppm_to_palette_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rpd_pkg::*;

  localparam int CYCLE_LIMIT     = 600000;
  localparam int RANDOM_ITEMS    = 260;
  localparam int SETTLE_CYCLES   = 16;
  localparam int HOLD_CYCLES     = 300;
  localparam int DIRECTED_COUNT  = 25;

  localparam int RX_ALWAYS   = 0;
  localparam int RX_RANDOM   = 1;
  localparam int RX_PERIODIC = 2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [16:0] width;
    logic [16:0] height;
    logic [7:0]  index;
    logic        last;
  } decoded_result_t;

  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } file_byte_t;

  typedef struct packed {
    logic [7:0]  data;
    logic        eos;
    logic        typed;
    logic [1:0]  kind;
    logic [16:0] width;
    logic [16:0] height;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"X",   1'b1, 1'b1, KIND_ERROR,  17'd0,     17'd0},
    '{8'h0E, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"P",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"6",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h20, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"9",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"9",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"9",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"9",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"9",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h0A, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"-",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"5",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h09, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"1",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h20, 1'b0, 1'b1, KIND_HEADER, 17'd99999, 17'd0},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'hFF, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h82, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h00, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h81, 1'b1, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{8'h03, 1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"P",   1'b0, 1'b0, KIND_HEADER, 17'd0,     17'd0},
    '{"6",   1'b1, 1'b1, KIND_HEADER, 17'd0,     17'd0}
  };

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [7:0]             in_tdata = 8'h00;
  logic                   in_tlast = 1'b0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [1:0]             out_tuser;
  logic                   out_tlast;

  rle_ppm_to_palette_decoder DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // decoder state mirror
  logic [1:0]  run_mode;
  logic [7:0]  run_left;
  logic [2:0]  hdr_phase;
  logic [7:0]  tok_buf [TOKEN_MAX];
  int unsigned tok_len;
  logic [16:0] img_w;
  logic [16:0] img_h;
  logic [7:0]  rgb_buf [2];
  int unsigned rgb_cnt;

  decoded_result_t step_results[$];
  decoded_result_t pending_results[$];
  logic [7:0]      plain_bytes[$];
  file_byte_t      file_bytes[$];

  int errors = 0;
  int cycle_count = 0;
  int burst_left = 0;
  bit no_gaps = 1'b0;
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int rx_pattern = RX_ALWAYS;

  task automatic clear_decoder();
    run_mode  = MODE_COUNTER;
    run_left  = 8'd0;
    hdr_phase = PH_MAGIC;
    tok_len   = 0;
    img_w     = 17'd0;
    img_h     = 17'd0;
    rgb_cnt   = 0;
  endtask

  task automatic add_result(input logic [1:0] kind, input logic [16:0] w,
                            input logic [16:0] h, input logic [7:0] idx);
    decoded_result_t res;
    res = '{kind, w, h, idx, 1'b0};
    step_results.push_back(res);
  endtask

  function automatic logic [16:0] token_value();
    int unsigned i;
    int unsigned v;
    bit neg;
    bit stop;
    i = 0;
    v = 0;
    neg = 1'b0;
    stop = 1'b0;
    if (tok_len > 0 && (tok_buf[0] == "+" || tok_buf[0] == "-")) begin
      neg = (tok_buf[0] == "-");
      i = 1;
    end
    while (!stop && i < tok_len) begin
      if (tok_buf[i] < "0" || tok_buf[i] > "9") begin
        stop = 1'b1;
      end else begin
        v = v * 10 + (tok_buf[i] - "0");
        if (v > DIM_MAX) v = DIM_MAX;
        i++;
      end
    end
    return neg ? 17'd0 : v[16:0];
  endfunction

  task automatic close_token();
    case (hdr_phase)
      PH_MAGIC: begin
        if (tok_len == 2 && tok_buf[0] == "P" && tok_buf[1] == "6") begin
          hdr_phase = PH_WIDTH;
        end else begin
          add_result(KIND_ERROR, 17'd0, 17'd0, 8'd0);
          hdr_phase = PH_ERROR;
        end
      end
      PH_WIDTH: begin
        img_w = token_value();
        hdr_phase = PH_HEIGHT;
      end
      PH_HEIGHT: begin
        img_h = token_value();
        hdr_phase = PH_MAXCOL;
      end
      default: begin
        add_result(KIND_HEADER, img_w, img_h, 8'd0);
        hdr_phase = PH_PIXELS;
      end
    endcase
    tok_len = 0;
  endtask

  task automatic feed_decoded(input logic [7:0] b);
    int r;
    int g;
    int bl;
    if (hdr_phase == PH_ERROR) return;
    if (hdr_phase == PH_PIXELS) begin
      if (rgb_cnt < 2) begin
        rgb_buf[rgb_cnt] = b;
        rgb_cnt++;
      end else begin
        r  = int'(rgb_buf[0]) / 51;
        g  = (2 * int'(rgb_buf[1])) / 85;
        bl = int'(b) / 51;
        add_result(KIND_PIXEL, 17'd0, 17'd0, 8'(r * 42 + g * 6 + bl));
        rgb_cnt = 0;
      end
      return;
    end
    if (b <= TOKEN_SPACE || tok_len >= TOKEN_MAX) begin
      close_token();
    end else begin
      tok_buf[tok_len] = b;
      tok_len++;
    end
  endtask

  task automatic decode_byte(input logic [7:0] d, input logic eos);
    decoded_result_t tail;
    step_results.delete();
    case (run_mode)
      MODE_COUNTER: begin
        if (d == 8'd0) begin
          run_mode = MODE_FOREVER;
        end else if (d > RUN_BASE) begin
          run_mode = MODE_REPEAT;
          run_left = d - RUN_BASE;
        end else begin
          run_mode = MODE_LITERAL;
          run_left = d;
        end
      end
      MODE_LITERAL: begin
        feed_decoded(d);
        if (run_left > 0) run_left = run_left - 8'd1;
        if (run_left == 0) run_mode = MODE_COUNTER;
      end
      MODE_REPEAT: begin
        for (int k = 0; k < int'(run_left) && k < 127; k++) feed_decoded(d);
        run_left = 8'd0;
        run_mode = MODE_COUNTER;
      end
      default: feed_decoded(d);
    endcase
    if (eos) begin
      while (hdr_phase < PH_PIXELS) close_token();
      clear_decoder();
    end
    if (step_results.size() > 0) begin
      tail = step_results.pop_back();
      tail.last = 1'b1;
      step_results.push_back(tail);
    end
  endtask

  task automatic send_item(input logic [7:0] d, input logic eos, input logic use_typed,
                           input decoded_result_t typed_res);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= d;
    in_tlast  <= eos;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_byte(d, eos);
    if (use_typed) begin
      pending_results.push_back(typed_res);
    end else begin
      foreach (step_results[k]) pending_results.push_back(step_results[k]);
    end
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic logic [7:0] pick_component();
    logic [7:0] edges [15] = '{8'd0, 8'd42, 8'd43, 8'd50, 8'd51, 8'd84, 8'd85, 8'd127,
                               8'd128, 8'd169, 8'd170, 8'd212, 8'd213, 8'd254, 8'd255};
    if ($urandom_range(0, 9) < 3) return edges[$urandom_range(0, 14)];
    return 8'($urandom);
  endfunction

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) plain_bytes.push_back(s[i]);
  endtask

  task automatic push_sep();
    plain_bytes.push_back(8'($urandom_range(0, 32)));
    if ($urandom_range(0, 9) == 0) plain_bytes.push_back(8'($urandom_range(0, 32)));
  endtask

  task automatic push_number();
    int len;
    int sign;
    sign = $urandom_range(0, 9);
    if (sign == 0) plain_bytes.push_back("-");
    else if (sign == 1) plain_bytes.push_back("+");
    len = $urandom_range(1, 5);
    if ($urandom_range(0, 9) == 0) len = $urandom_range(0, 7);
    repeat (len) begin
      if ($urandom_range(0, 11) == 0) plain_bytes.push_back(8'($urandom_range(33, 255)));
      else plain_bytes.push_back(8'("0" + $urandom_range(0, 9)));
    end
  endtask

  task automatic push_pixels();
    int n;
    int run;
    logic [7:0] v;
    n = $urandom_range(0, 36);
    repeat (n) plain_bytes.push_back(pick_component());
    if ($urandom_range(0, 3) == 0) begin
      v = pick_component();
      run = $urandom_range(3, 127);
      repeat (run) plain_bytes.push_back(v);
    end
    repeat ($urandom_range(0, 9)) plain_bytes.push_back(pick_component());
  endtask

  task automatic push_header_and_pixels();
    push_text("P6");
    push_sep();
    push_number();
    push_sep();
    push_number();
    push_sep();
    push_text("255");
    push_sep();
    push_pixels();
  endtask

  task automatic build_plain();
    int style;
    int keep;
    plain_bytes.delete();
    style = $urandom_range(0, 9);
    if (style <= 6) begin
      push_header_and_pixels();
    end else if (style == 7) begin
      case ($urandom_range(0, 3))
        0: push_text("P5");
        1: push_text("P");
        2: push_text("P66");
        default: repeat ($urandom_range(1, 4)) plain_bytes.push_back(8'($urandom_range(33, 255)));
      endcase
      push_sep();
      push_number();
      push_sep();
      push_pixels();
    end else if (style == 8) begin
      push_header_and_pixels();
      keep = $urandom_range(0, plain_bytes.size());
      while (plain_bytes.size() > keep) plain_bytes.delete(plain_bytes.size() - 1);
    end else begin
      repeat ($urandom_range(1, 12)) plain_bytes.push_back(8'($urandom));
    end
  endtask

  task automatic push_file_byte(input logic [7:0] d);
    file_byte_t fb;
    fb = '{d, 1'b0};
    file_bytes.push_back(fb);
  endtask

  task automatic encode_stream();
    int i;
    int n;
    int rl;
    int len;
    int style;
    int keep;
    file_byte_t fb;
    file_bytes.delete();
    i = 0;
    n = plain_bytes.size();
    while (i < n) begin
      rl = 1;
      while (i + rl < n && rl < 127 && plain_bytes[i + rl] == plain_bytes[i]) rl++;
      style = $urandom_range(0, 19);
      if (style == 0) begin
        push_file_byte(8'h00);
        while (i < n) begin
          push_file_byte(plain_bytes[i]);
          i++;
        end
      end else if ((rl >= 2 && style < 15) || style == 1) begin
        push_file_byte(8'(RUN_BASE + rl));
        push_file_byte(plain_bytes[i]);
        i += rl;
      end else begin
        len = (style == 2) ? 128 : $urandom_range(1, 8);
        if (style != 2 && len > n - i) len = n - i;
        push_file_byte(8'(len));
        for (int j = 0; j < len && i < n; j++) begin
          push_file_byte(plain_bytes[i]);
          i++;
        end
      end
    end
    if (file_bytes.size() == 0 || $urandom_range(0, 6) == 0) push_file_byte(8'($urandom));
    if (file_bytes.size() > 1 && $urandom_range(0, 9) == 0) begin
      keep = $urandom_range(1, file_bytes.size());
      while (file_bytes.size() > keep) file_bytes.delete(file_bytes.size() - 1);
    end
    fb = file_bytes.pop_back();
    fb.eos = 1'b1;
    file_bytes.push_back(fb);
  endtask

  // receiver backpressure
  always @(posedge clk) begin
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        pattern_left = $urandom_range(20, 200);
        rx_pattern = $urandom_range(RX_ALWAYS, RX_PERIODIC);
      end
      pattern_left--;
      case (rx_pattern)
        RX_ALWAYS: out_tready <= 1'b1;
        RX_RANDOM: out_tready <= 1'($urandom_range(0, 1));
        default:   out_tready <= (pattern_left % 3 == 0);
      endcase
    end
  end

  always @(posedge clk) begin
    decoded_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result kind %0d tdata %h last %0d", $time, out_tuser,
                 out_tdata, out_tlast);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (out_tuser !== want.kind) begin
          $display("%0t: kind expected %0d actual %0d", $time, want.kind, out_tuser);
          errors++;
        end
        if (out_tdata[16:0] !== want.width) begin
          $display("%0t: image_width expected %0d actual %0d", $time, want.width,
                   out_tdata[16:0]);
          errors++;
        end
        if (out_tdata[33:17] !== want.height) begin
          $display("%0t: image_height expected %0d actual %0d", $time, want.height,
                   out_tdata[33:17]);
          errors++;
        end
        if (out_tdata[41:34] !== want.index) begin
          $display("%0t: color_index expected %0d actual %0d", $time, want.index,
                   out_tdata[41:34]);
          errors++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last expected %0d actual %0d", $time, want.last, out_tlast);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("rle_ppm_to_palette_decoder_tb failed");
      $finish;
    end
  end

  initial begin
    directed_row_t row;
    decoded_result_t typed_res;
    int random_items;
    int stream_no;
    clear_decoder();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    for (int r = 0; r < DIRECTED_COUNT; r++) begin
      row = DIRECTED_ROWS[r];
      typed_res = '{row.kind, row.width, row.height, 8'd0, 1'b1};
      send_item(row.data, row.eos, row.typed, typed_res);
    end

    random_items = 0;
    stream_no = 0;
    while (random_items < RANDOM_ITEMS) begin
      build_plain();
      encode_stream();
      no_gaps = ($urandom_range(0, 3) == 0);
      if (stream_no == 2 || $urandom_range(0, 24) == 0) hold_requests++;
      foreach (file_bytes[k]) begin
        send_item(file_bytes[k].data, file_bytes[k].eos, 1'b0, '0);
        random_items++;
      end
      if (stream_no == 4 || $urandom_range(0, 7) == 0) drain_results();
      stream_no++;
    end

    drain_results();
    if (errors == 0 && pending_results.size() == 0) begin
      $display("rle_ppm_to_palette_decoder_tb passed");
    end else begin
      $display("rle_ppm_to_palette_decoder_tb failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
